// File: hw/rtl/bblur_pkg.sv
package bblur_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int HEIGHT_LIMIT      = 4096;

    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int SUM_W       = 12;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_W    = 13;
    localparam int ROW_W       = 13;
    localparam int OUT_ROW_W   = 12;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 13;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 13'd480;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // floor(x / d) = (x * ceil(2^20 / d)) >> 20, exact for x below 2^13
    localparam int              RECIP_SHIFT = 20;
    localparam int              RECIP_W     = 17;
    localparam int              PROD_W      = SUM_W + 1 + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_12 = 17'd87382;
    localparam logic [RECIP_W-1:0] RECIP_18 = 17'd58255;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_sel_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic top_ok;
        logic bottom_ok;
        logic left_ok;
        logic right_ok;
    } nbr_ctl_t;

    // round-half-up mean: floor((2*sum + n) / (2*n))
    function automatic logic [CHAN_W-1:0] round_mean(input logic [SUM_W-1:0] sum,
                                                     input div_sel_t sel);
        logic [SUM_W:0]    x;
        logic [PROD_W-1:0] prod;
        logic [CHAN_W-1:0] q;
        x    = '0;
        prod = '0;
        case (sel)
            DIV_BY_4: begin
                x = {1'b0, sum} + (SUM_W+1)'(2);
                q = x[2 +: CHAN_W];
            end
            DIV_BY_6: begin
                x    = {sum, 1'b0} + (SUM_W+1)'(6);
                prod = PROD_W'(x) * PROD_W'(RECIP_12);
                q    = prod[RECIP_SHIFT +: CHAN_W];
            end
            DIV_BY_9: begin
                x    = {sum, 1'b0} + (SUM_W+1)'(9);
                prod = PROD_W'(x) * PROD_W'(RECIP_18);
                q    = prod[RECIP_SHIFT +: CHAN_W];
            end
            default: begin
                q = '0;
            end
        endcase
        return q;
    endfunction

endpackage

// File: hw/rtl/bblur_line_ram.sv
module bblur_line_ram #(
    parameter int DEPTH  = bblur_pkg::MAX_WIDTH_DEFAULT,
    parameter int DATA_W = 2 * bblur_pkg::PIX_W,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/box_blur_3x3_shrinking_border_core.sv
// A releasing input beat passes stages 1, 2, 3 and the output register to give a result.
// Throughput: one beat per clock unless the output stalls, set by the single line memory
// read and write per beat. The line memory holds the rows two back and one back.
// Reset (aresetn low, synchronous): stream positions and pipeline cleared,
// width back to 640, height back to 480; line memory is not cleared and needs no pass.
module box_blur_3x3_shrinking_border_core #(
    parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bblur_pkg::PIX_W-1:0]       s_tdata,   // red, green, blue
    input  logic [0:0]                        s_tuser,   // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bblur_pkg::PIX_W-1:0]       m_tdata,   // out_red, out_green, out_blue
    output logic                              m_tlast,   // frame_end
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bblur_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bblur_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = COL_W + 1;

    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [WID_W-1:0]       w_used;
    logic [HEIGHT_W-1:0]    h_used;

    logic [ROW_W-1:0]     in_row_reg, in_row_next;
    logic [COL_W-1:0]     in_col_reg, in_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;

    logic             cfg_wr;
    logic             restart;
    logic             accept;
    logic             draining;
    logic             ignore;
    logic             enter;
    logic [PIX_W-1:0] s0_pix;
    nbr_ctl_t         s0_ctl;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    nbr_ctl_t         s1_ctl_reg;
    logic             s1_ready;
    logic             s1_adv;

    logic [2*PIX_W-1:0] ram_rd_data;
    logic [2*PIX_W-1:0] ram_wr_data;

    logic [PIX_W-1:0] win_reg [3][3];

    logic       s2_valid_reg;
    nbr_ctl_t   s2_ctl_reg;
    logic       s2_ready;
    logic [2:0] row_ok;
    logic [2:0] col_ok;

    logic [SUM_W-1:0] s3_sum_next [3];
    div_sel_t         s3_sel_next;
    logic             s3_valid_reg;
    logic [SUM_W-1:0] s3_sum_reg [3];
    div_sel_t         s3_sel_reg;
    logic             s3_last_reg;
    logic             s3_ready;

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_data_reg;
    logic [PIX_W-1:0] out_data_next;
    logic             out_last_reg;
    logic             out_ready;

    // configuration
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (cfg_index == CFG_IMAGE_WIDTH) begin
                width_reg <= cfg_data[WIDTH_REG_W-1:0];
            end
            if (cfg_index == CFG_IMAGE_HEIGHT) begin
                height_reg <= cfg_data[HEIGHT_W-1:0];
            end
        end
    end

    always_comb begin
        if (width_reg < WIDTH_REG_W'(2)) begin
            w_used = WID_W'(2);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_used = WID_W'(MAX_WIDTH);
        end else begin
            w_used = WID_W'(width_reg);
        end
        if (height_reg < HEIGHT_W'(2)) begin
            h_used = HEIGHT_W'(2);
        end else if (32'(height_reg) > HEIGHT_LIMIT) begin
            h_used = HEIGHT_W'(HEIGHT_LIMIT);
        end else begin
            h_used = height_reg;
        end
    end

    // input beat decode
    assign s_tready = s1_ready;
    assign accept   = s_tvalid && s_tready;
    assign draining = in_row_reg >= h_used;
    assign ignore   = !draining && (s_tuser[0] == OP_DRAIN);
    assign enter    = accept && !ignore;
    assign s0_pix   = draining ? '0 : s_tdata;

    always_comb begin
        s0_ctl.emit      = (in_row_reg >= ROW_W'(2)) ||
                           (in_row_reg == ROW_W'(1) && in_col_reg != '0);
        s0_ctl.top_ok    = out_row_reg != '0;
        s0_ctl.bottom_ok = (HEIGHT_W'(out_row_reg) + HEIGHT_W'(1)) < h_used;
        s0_ctl.left_ok   = out_col_reg != '0;
        s0_ctl.right_ok  = (WID_W'(out_col_reg) + WID_W'(1)) < w_used;
        s0_ctl.last      = !s0_ctl.bottom_ok && !s0_ctl.right_ok;
    end

    always_comb begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (restart) begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end else if (enter) begin
            if ((WID_W'(in_col_reg) + WID_W'(1)) >= w_used) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (s0_ctl.emit) begin
                if (!s0_ctl.right_ok) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OUT_ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
                if (s0_ctl.last) begin
                    in_row_next  = '0;
                    in_col_next  = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // stage 1: line memory read data arrives; write back on advance
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_adv   = s1_valid_reg && s2_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= enter;
        end
    end

    always_ff @(posedge aclk) begin
        if (enter) begin
            s1_pix_reg <= s0_pix;
            s1_col_reg <= in_col_reg;
            s1_ctl_reg <= s0_ctl;
        end
    end

    // upper half holds the row two back, lower half the row one back
    assign ram_wr_data = {ram_rd_data[PIX_W-1:0], s1_pix_reg};

    bblur_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIX_W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (ram_wr_data),
        .rd_en   (enter),
        .rd_addr (in_col_reg),
        .rd_data (ram_rd_data)
    );

    // window columns advance left; new column enters on the right
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= ram_rd_data[2*PIX_W-1:PIX_W];
            win_reg[1][2] <= ram_rd_data[PIX_W-1:0];
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    // stage 2: masked neighborhood sums
    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_comb begin
        row_ok = {s2_ctl_reg.bottom_ok, 1'b1, s2_ctl_reg.top_ok};
        col_ok = {s2_ctl_reg.right_ok, 1'b1, s2_ctl_reg.left_ok};
        for (int ch = 0; ch < 3; ch++) begin
            s3_sum_next[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (row_ok[r] && col_ok[c]) begin
                        s3_sum_next[ch] = s3_sum_next[ch] +
                                          SUM_W'(win_reg[r][c][ch*CHAN_W +: CHAN_W]);
                    end
                end
            end
        end
        if (s2_ctl_reg.top_ok && s2_ctl_reg.bottom_ok &&
            s2_ctl_reg.left_ok && s2_ctl_reg.right_ok) begin
            s3_sel_next = DIV_BY_9;
        end else if ((s2_ctl_reg.top_ok && s2_ctl_reg.bottom_ok) ||
                     (s2_ctl_reg.left_ok && s2_ctl_reg.right_ok)) begin
            s3_sel_next = DIV_BY_6;
        end else begin
            s3_sel_next = DIV_BY_4;
        end
    end

    // stage 3: sums held for the divide
    assign s3_ready = !s3_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && s2_valid_reg) begin
            s3_sum_reg  <= s3_sum_next;
            s3_sel_reg  <= s3_sel_next;
            s3_last_reg <= s2_ctl_reg.last;
        end
    end

    // output register
    assign out_ready = !out_valid_reg || m_tready;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            out_data_next[ch*CHAN_W +: CHAN_W] = round_mean(s3_sum_reg[ch], s3_sel_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s3_valid_reg) begin
            out_data_reg <= out_data_next;
            out_last_reg <= s3_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        WID_W'(in_col_reg) < w_used)
        else $error("input column beyond frame width");

    a_row_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        in_row_reg <= ROW_W'(h_used) + ROW_W'(1))
        else $error("input row ran past the drain rows");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (enter && s0_ctl.emit && s0_ctl.last) |=>
            (in_row_reg == '0 && in_col_reg == '0 &&
             out_row_reg == '0 && out_col_reg == '0))
        else $error("frame end did not restart stream positions");

endmodule

// File: tb/tb_box_blur_3x3_shrinking_border_core.sv
module tb_box_blur_3x3_shrinking_border_core;
    import bblur_pkg::*;

    localparam int MAX_W        = MAX_WIDTH_DEFAULT;
    localparam int RANDOM_BEATS = 560;
    localparam int HOLD_BEATS   = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_PAUSE  = 8;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic op;
        rgb_t pix;
    } pixel_beat_t;

    typedef struct packed {
        logic frame_end;
        rgb_t pix;
    } blur_out_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata   = '0;   // red, green, blue
    logic [0:0]             s_tuser   = '0;   // operation
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [PIX_W-1:0]       m_tdata;          // out_red, out_green, out_blue
    logic                   m_tlast;          // frame_end
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    box_blur_3x3_shrinking_border_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // blur predictor state
    logic [WIDTH_REG_W-1:0] reg_width  = WIDTH_RESET;
    logic [HEIGHT_W-1:0]    reg_height = HEIGHT_RESET;
    rgb_t                   line_up  [MAX_W];
    rgb_t                   line_mid [MAX_W];
    rgb_t                   win [3][3];
    int unsigned            row_in, col_in, row_out, col_out;

    pixel_beat_t pixel_q[$];
    blur_out_t   blur_expect_q[$];

    bit          in_fire, out_fire, cfg_fire;
    bit          quiet    = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned idle_pct = 0;
    int unsigned tx_gap, rx_gap, hold_left, stall_cycles;
    int unsigned beats_queued, beats_taken, random_beats, fail_count;

    function automatic int unsigned eff_width();
        if (reg_width < 2) return 2;
        if (reg_width > MAX_W) return MAX_W;
        return 32'(reg_width);
    endfunction

    function automatic int unsigned eff_height();
        if (reg_height < 2) return 2;
        if (reg_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return 32'(reg_height);
    endfunction

    function automatic void restart_frame();
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                win[y][x] = '0;
        row_in  = 0;
        col_in  = 0;
        row_out = 0;
        col_out = 0;
    endfunction

    // mean over in-frame neighbors; view column x maps to window column x+off
    function automatic rgb_t box_mean(input int unsigned off);
        int unsigned sr, sg, sb, n, w, h, k;
        bit          rok, cok;
        rgb_t        res;
        sr = 0;
        sg = 0;
        sb = 0;
        n  = 0;
        w  = eff_width();
        h  = eff_height();
        for (int y = 0; y < 3; y++) begin
            rok = (y == 0) ? (row_out >= 1) : ((y == 1) ? 1'b1 : (row_out + 1 < h));
            if (rok) begin
                for (int x = 0; x < 3; x++) begin
                    cok = (x == 0) ? (col_out >= 1) : ((x == 1) ? 1'b1 : (col_out + 1 < w));
                    k   = x + off;
                    if (cok && k < 3) begin
                        sr += 32'(win[y][k].red);
                        sg += 32'(win[y][k].green);
                        sb += 32'(win[y][k].blue);
                        n++;
                    end
                end
            end
        end
        if (n == 0) n = 1;
        res.red   = CHAN_W'((2 * sr + n) / (2 * n));
        res.green = CHAN_W'((2 * sg + n) / (2 * n));
        res.blue  = CHAN_W'((2 * sb + n) / (2 * n));
        return res;
    endfunction

    task automatic blur_predict(input pixel_beat_t beat);
        int unsigned w, h, c;
        bit          draining, emit;
        rgb_t        px, res;
        blur_out_t   item;
        w        = eff_width();
        h        = eff_height();
        draining = row_in >= h;
        if (!draining && beat.op == OP_DRAIN) return;
        px   = draining ? rgb_t'(0) : beat.pix;
        c    = (col_in >= MAX_W) ? 0 : col_in;
        emit = (row_in >= 2) || (row_in == 1 && c >= 1);
        res  = '0;
        if (emit && c == 0) res = box_mean(1);
        for (int y = 0; y < 3; y++) begin
            win[y][0] = win[y][1];
            win[y][1] = win[y][2];
        end
        win[0][2]   = line_up[c];
        win[1][2]   = line_mid[c];
        win[2][2]   = px;
        line_up[c]  = line_mid[c];
        line_mid[c] = px;
        if (emit && c != 0) res = box_mean(0);
        col_in = c + 1;
        if (col_in >= w) begin
            col_in = 0;
            row_in++;
        end
        if (!emit) return;
        item.pix       = res;
        item.frame_end = (row_out + 1 >= h) && (col_out + 1 >= w);
        blur_expect_q.push_back(item);
        col_out++;
        if (col_out >= w) begin
            col_out = 0;
            row_out++;
        end
        if (item.frame_end) restart_frame();
    endtask

    always @(posedge aclk) begin : monitor
        blur_out_t got, want;
        in_fire  = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        cfg_fire = aresetn && cfg_valid && cfg_ready;
        if (cfg_fire) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    reg_width = cfg_data[WIDTH_REG_W-1:0];
                    restart_frame();
                end
                CFG_IMAGE_HEIGHT: begin
                    reg_height = cfg_data[HEIGHT_W-1:0];
                    restart_frame();
                end
                default: ;
            endcase
        end
        if (in_fire) begin
            blur_predict({s_tuser[0], s_tdata});
            beats_taken++;
        end
        if (out_fire) begin
            got.pix       = m_tdata;
            got.frame_end = m_tlast;
            if (blur_expect_q.size() == 0) begin
                $error("result beat with no pixel expected: data %h last %b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = blur_expect_q.pop_front();
                if (got.pix.red !== want.pix.red) begin
                    $error("out_red expected %0d got %0d", want.pix.red, got.pix.red);
                    fail_count++;
                end
                if (got.pix.green !== want.pix.green) begin
                    $error("out_green expected %0d got %0d", want.pix.green, got.pix.green);
                    fail_count++;
                end
                if (got.pix.blue !== want.pix.blue) begin
                    $error("out_blue expected %0d got %0d", want.pix.blue, got.pix.blue);
                    fail_count++;
                end
                if (got.frame_end !== want.frame_end) begin
                    $error("frame_end expected %0b got %0b", want.frame_end, got.frame_end);
                    fail_count++;
                end
            end
        end
        if (!aresetn || in_fire || out_fire || cfg_fire) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin : pixel_driver
        pixel_beat_t nxt;
        if (aresetn && !(s_tvalid && !in_fire)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                nxt = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.pix;
                s_tuser  <= nxt.op;
                if (!quiet && $urandom_range(0, 99) < idle_pct) tx_gap = $urandom_range(1, 11);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < idle_pct) rx_gap = $urandom_range(1, 11);
        end
    end

    function automatic logic [CHAN_W-1:0] pick_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic rgb_t rand_rgb();
        rgb_t px;
        px.red   = pick_chan();
        px.green = pick_chan();
        px.blue  = pick_chan();
        return px;
    endfunction

    task automatic push_beat(input logic op, input rgb_t px);
        pixel_beat_t beat;
        beat.op  = op;
        beat.pix = px;
        pixel_q.push_back(beat);
        beats_queued++;
    endtask

    task automatic settle();
        while (beats_taken != beats_queued || blur_expect_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_PAUSE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic resize(input logic [CFG_DATA_W-1:0] w_val,
                          input logic [CFG_DATA_W-1:0] h_val);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w_val);
        write_reg(CFG_IMAGE_HEIGHT, h_val);
    endtask

    function automatic int unsigned full_frame_beats();
        return eff_width() * eff_height() + eff_width() + 1;
    endfunction

    // pixels first, then drain beats; early drain ticks mixed in when noisy
    task automatic queue_frame(input int unsigned n_items, input bit noisy);
        int unsigned area;
        area = eff_width() * eff_height();
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i < area) begin
                if (noisy && $urandom_range(0, 11) == 0) push_beat(OP_DRAIN, rand_rgb());
                push_beat(OP_PIXEL, rand_rgb());
            end else begin
                push_beat(($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN, rand_rgb());
            end
            random_beats++;
        end
    endtask

    initial begin : stimulus
        int unsigned w, h, n;
        bit          need_restart;
        rgb_t        px;
        restart_frame();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        resize(13'h1800, 13'd1);
        push_beat(OP_PIXEL, rgb_t'('1));
        push_beat(OP_DRAIN, rgb_t'('1));
        push_beat(OP_PIXEL, rgb_t'('0));
        px = '{blue: 8'h80, green: 8'h00, red: 8'hFF};
        push_beat(OP_PIXEL, px);
        px = '{blue: 8'h7F, green: 8'hFE, red: 8'h01};
        push_beat(OP_PIXEL, px);
        push_beat(OP_DRAIN, rgb_t'('0));
        push_beat(OP_PIXEL, rgb_t'('1));
        push_beat(OP_DRAIN, rgb_t'('1));

        resize(13'd3, 13'd3);
        for (int i = 0; i < 9; i++) begin
            px.red   = i[0] ? 8'hFF : 8'h00;
            px.green = 8'(i * 31);
            px.blue  = 8'(255 - i * 17);
            push_beat(OP_PIXEL, px);
        end
        for (int i = 0; i < 4; i++) push_beat((i == 2) ? OP_PIXEL : OP_DRAIN, rand_rgb());

        resize(13'd1, 13'd0);
        queue_frame(full_frame_beats(), 1'b1);

        // hold the sink while a tall frame keeps streaming in
        idle_pct = 10;
        resize(13'd0, 13'd8191);
        hold_req = 1'b1;
        queue_frame(HOLD_BEATS, 1'b0);

        random_beats = 0;
        need_restart = 1'b1;
        while (random_beats < RANDOM_BEATS) begin
            if (random_beats + 120 > RANDOM_BEATS) quiet = 1'b1;
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 12;
                default: idle_pct = 40;
            endcase
            if (need_restart || $urandom_range(0, 2) == 0) begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(2, 10);
                h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(2, 6);
                resize({2'($urandom), 11'(w)}, 13'(h));
                need_restart = 1'b0;
            end
            n = full_frame_beats();
            if ($urandom_range(0, 7) == 0) begin
                n            = $urandom_range(1, n - 1);
                need_restart = 1'b1;
            end
            queue_frame(n, $urandom_range(0, 3) == 0);
        end

        settle();
        if (fail_count == 0 && blur_expect_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bblur_pkg.sv
hw/rtl/bblur_line_ram.sv
hw/rtl/box_blur_3x3_shrinking_border_core.sv
tb/tb_box_blur_3x3_shrinking_border_core.sv
